// ===== sv/htbp_pkg.sv =====
// Package: constants, command codes and the lookup-to-packer struct.
`default_nettype none
package htbp_pkg;
	localparam int MaxCodeBits = 32;
	localparam int CodeW       = 32;
	localparam int LenW        = 6;
	localparam int SymW        = 9;
	localparam int EntryCount  = 257;
	localparam int AddrW       = $clog2(EntryCount);
	localparam int AccW        = CodeW + 8;
	localparam int CntW        = 6;
	localparam int WordW       = LenW + CodeW;
	localparam logic [AddrW-1:0] EosSymbol = AddrW'(256);

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_DATA = 2'd1,
		CMD_END  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic             valid;
		logic             finish;
		logic [LenW-1:0]  len;
		logic [CodeW-1:0] code;
	} lk_t;
endpackage
`default_nettype wire

// ===== sv/huffman_table_bit_packer_top.sv =====
// Top level of the table-driven Huffman bit packer.
// A load beat (command 0) writes one code table entry and yields no output. A data beat
// (command 1) looks up the code of symbol[7:0]; an end beat (command 2) looks up the
// end-of-stream code (symbol 256), pads to a byte and flushes. The table is one
// 257 x 38 synchronous RAM read once per data or end beat; the registered lookup result
// enters the bit accumulator once it holds no whole byte, and the accumulator then sends
// out one byte per cycle, while out_ready allows, through a registered output. An item
// completes at most 5 bytes; while the accumulator holds a whole byte the lookup result
// waits, and a new beat is accepted only when the lookup register is empty or taken.
// run_end marks the last byte of each beat, stream_end the padded last byte of a stream.
`default_nettype none
module huffman_table_bit_packer_top
	import htbp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [SymW-1:0]  symbol,
	input  wire logic [CodeW-1:0] code_value,
	input  wire logic [LenW-1:0]  code_length,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_end,
	output logic                  stream_end
);
	lk_t  lk;
	logic take;

	htbp_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.symbol     (symbol),
		.code_value (code_value),
		.code_length(code_length),
		.take       (take),
		.lk         (lk)
	);

	htbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.lk        (lk),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.stream_end(stream_end)
	);

	a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_end)
		else $error("stream_end without run_end");

	a_lookup_holds: assert property (@(posedge clk) disable iff (!arst_n)
		lk.valid && !take |=> lk.valid && $stable(lk.code) && $stable(lk.len))
		else $error("stalled lookup result changed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !lk.valid || take)
		else $error("beat accepted over a held lookup");
endmodule
`default_nettype wire

// ===== sv/htbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module htbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/htbp_lookup.sv =====
// Input stage: table writes, code table lookup and the lookup pipeline register.
`default_nettype none
module htbp_lookup
	import htbp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      command,
	input  wire logic [SymW-1:0] symbol,
	input  wire logic [CodeW-1:0] code_value,
	input  wire logic [LenW-1:0] code_length,
	input  wire logic            take,
	output lk_t                  lk
);
	logic                  lk_valid_s1;
	logic                  fin_s1;
	logic                  vld_rd_s1;
	logic [EntryCount-1:0] vld_q;
	logic                  in_beat;
	logic                  is_rd;
	logic                  is_wr;
	logic [AddrW-1:0]      rd_addr;
	logic [LenW-1:0]       len_sat;
	logic [CodeW-1:0]      mask;
	logic [WordW-1:0]      rdata;

	always_comb begin
		in_ready = !lk_valid_s1 || take;
		in_beat  = in_valid && in_ready;
		is_rd    = in_beat && (command == CMD_DATA || command == CMD_END);
		is_wr    = in_beat && command == CMD_LOAD && symbol <= EosSymbol;
		rd_addr  = (command == CMD_END) ? EosSymbol : {1'b0, symbol[7:0]};
		len_sat  = (code_length > LenW'(MaxCodeBits)) ? LenW'(MaxCodeBits) : code_length;
		mask     = CodeW'(~({(CodeW+1){1'b1}} << len_sat));
	end

	htbp_ram #(
		.WIDTH(WordW),
		.DEPTH(EntryCount)
	) u_table (
		.clk  (clk),
		.we   (is_wr),
		.waddr(symbol),
		.wdata({len_sat, code_value & mask}),
		.re   (is_rd),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_valid_s1 <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (is_rd) begin
				lk_valid_s1 <= 1'b1;
			end else if (take) begin
				lk_valid_s1 <= 1'b0;
			end
			if (is_wr) begin
				vld_q[symbol] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_rd) begin
			fin_s1    <= (command == CMD_END);
			vld_rd_s1 <= vld_q[rd_addr];
		end
	end

	always_comb begin
		lk.valid  = lk_valid_s1;
		lk.finish = fin_s1;
		lk.len    = vld_rd_s1 ? rdata[WordW-1:CodeW] : '0;
		lk.code   = vld_rd_s1 ? rdata[CodeW-1:0] : '0;
	end
endmodule
`default_nettype wire

// ===== sv/htbp_packer.sv =====
// Bit accumulator: appends codes, pads at end of stream, emits one byte per cycle while out_ready allows.
`default_nettype none
module htbp_packer
	import htbp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire lk_t   lk,
	output logic       take,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       stream_end
);
	logic [AccW-1:0] acc_q;
	logic [CntW-1:0] tot_q;
	logic            fin_q;
	logic            out_valid_q;
	logic            busy;
	logic            emit;
	logic [AccW-1:0] code_al;
	logic [CntW-1:0] tot_new;
	logic [CntW-1:0] tot_pad;

	always_comb begin
		busy    = tot_q[CntW-1:3] != '0;
		emit    = busy && (!out_valid_q || out_ready);
		take    = lk.valid && !busy;
		// left-align the code in the accumulator, then place it after pending bits
		code_al = {lk.code, 8'b0} << (LenW'(CodeW) - lk.len);
		tot_new = tot_q + CntW'(lk.len);
		tot_pad = tot_new;
		if (lk.finish && tot_new[2:0] != 3'd0) begin
			tot_pad = {tot_new[CntW-1:3] + 3'd1, 3'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			tot_q       <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= acc_q | (code_al >> tot_q[2:0]);
				tot_q <= tot_pad;
				fin_q <= lk.finish;
			end else if (emit) begin
				acc_q <= acc_q << 8;
				tot_q <= tot_q - CntW'(8);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte   <= acc_q[AccW-1:AccW-8];
			run_end    <= tot_q[CntW-1:3] == 3'd1;
			stream_end <= (tot_q[CntW-1:3] == 3'd1) && fin_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== test/huffman_table_bit_packer_top_tb.sv =====
// Testbench for the Huffman bit packer: directed and random beats against a table-driven predictor.
`timescale 1ns / 100ps
module huffman_table_bit_packer_top_tb;
	import htbp_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ShowLimit  = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       stream_end;
	} out_beat_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic [1:0]       command     = CMD_NONE;
	logic [SymW-1:0]  symbol      = '0;
	logic [CodeW-1:0] code_value  = '0;
	logic [LenW-1:0]  code_length = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [7:0]       out_byte;
	logic             run_end;
	logic             stream_end;

	huffman_table_bit_packer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.symbol     (symbol),
		.code_value (code_value),
		.code_length(code_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [CodeW-1:0] code_tbl [EntryCount];
	logic [LenW-1:0]  len_tbl  [EntryCount];
	bit               written  [EntryCount];
	logic [6:0]       pend_bits;
	logic [2:0]       pend_cnt;
	int               loaded_bytes[$];
	out_beat_t        byte_q[$];

	int        fail_count = 0;
	int        shown      = 0;
	int        burst_left = 0;
	int        hold_left  = 0;
	int        stall_left = 0;
	int        cycle_count = 0;
	bit        steady     = 1'b0;
	out_beat_t want;

	function automatic void note_failure(string msg);
		fail_count++;
		if (shown < ShowLimit) begin
			shown++;
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endfunction

	// append the code of one table entry, emit whole bytes, pad on finish
	function automatic void pack_code(int idx, bit finish);
		int         l;
		int         total;
		int         n;
		logic [39:0] acc;
		out_beat_t  ob [5];
		l = len_tbl[idx];
		total = int'(pend_cnt) + l;
		acc = (40'(pend_bits) << l) | (40'(code_tbl[idx]) & ((40'd1 << l) - 40'd1));
		if (finish && (total % 8) != 0) begin
			acc = acc << (8 - total % 8);
			total = total + 8 - total % 8;
		end
		n = 0;
		while (total >= 8) begin
			total -= 8;
			ob[n] = '{data: acc[total +: 8], run_end: 1'b0, stream_end: 1'b0};
			n++;
		end
		pend_bits = 7'(acc & ((40'd1 << total) - 40'd1));
		pend_cnt = 3'(total);
		if (n > 0) begin
			ob[n-1].run_end = 1'b1;
			ob[n-1].stream_end = finish;
		end
		for (int i = 0; i < n; i++)
			byte_q.push_back(ob[i]);
	endfunction

	function automatic void predict_beat(cmd_t cmd, logic [8:0] sym, logic [31:0] val,
			logic [5:0] len);
		int l;
		case (cmd)
			CMD_LOAD: begin
				if (sym < EntryCount) begin
					l = (len > MaxCodeBits) ? MaxCodeBits : int'(len);
					code_tbl[sym] = val & 32'((64'd1 << l) - 64'd1);
					len_tbl[sym] = LenW'(l);
					if (!written[sym]) begin
						written[sym] = 1'b1;
						if (sym < 256)
							loaded_bytes.push_back(int'(sym));
					end
				end
			end
			CMD_DATA: pack_code(int'(sym[7:0]), 1'b0);
			CMD_END:  pack_code(int'(EosSymbol), 1'b1);
			default: ;
		endcase
	endfunction

	// called in the step of a rising edge; returns in the step of the accepting edge
	task automatic send_beat(cmd_t cmd, logic [8:0] sym, logic [31:0] val, logic [5:0] len);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		command     <= cmd;
		symbol      <= sym;
		code_value  <= val;
		code_length <= len;
		do @(posedge clk); while (!in_ready);
		predict_beat(cmd, sym, val, len);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (byte_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [5:0] rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 6'd0;
		else if (r < 10)
			return 6'd32;
		else if (r < 15)
			return 6'($urandom_range(33, 63));
		else if (r < 25)
			return 6'($urandom_range(13, 31));
		return 6'($urandom_range(1, 12));
	endfunction

	function automatic logic [8:0] pick_data_sym();
		logic [7:0] b;
		b = 8'(loaded_bytes[$urandom_range(0, loaded_bytes.size() - 1)]);
		return {1'($urandom_range(0, 1)), b};
	endfunction

	task automatic test_empty_end();
		send_beat(CMD_LOAD, EosSymbol, 32'hFFFF_FFFF, 6'd0);
		send_beat(CMD_END, 9'd0, 32'd0, 6'd0);
		send_beat(CMD_END, 9'h1FF, 32'hFFFF_FFFF, 6'h3F);
		wait_drain();
	endtask

	task automatic test_length_saturation();
		send_beat(CMD_LOAD, 9'd0, 32'hFFFF_FFFF, 6'h3F);
		send_beat(CMD_DATA, 9'd0, 32'd0, 6'd0);
		send_beat(CMD_LOAD, 9'd2, 32'd0, 6'd32);
		send_beat(CMD_DATA, 9'd2, 32'hFFFF_FFFF, 6'h3F);
		wait_drain();
	endtask

	task automatic test_code_masking();
		send_beat(CMD_LOAD, 9'd255, 32'hFFFF_FFFF, 6'd3);
		send_beat(CMD_LOAD, 9'd1, 32'hFFFF_FFFF, 6'd0);
		send_beat(CMD_DATA, 9'd1, 32'd0, 6'd0);
		send_beat(CMD_DATA, 9'h1FF, 32'd0, 6'd0);
		wait_drain();
	endtask

	task automatic test_ignored_beats();
		send_beat(CMD_LOAD, 9'd257, $urandom(), 6'd5);
		send_beat(CMD_LOAD, 9'h1FF, 32'hFFFF_FFFF, 6'h3F);
		send_beat(CMD_NONE, 9'($urandom()), $urandom(), 6'($urandom()));
		send_beat(CMD_NONE, 9'h1FF, 32'hFFFF_FFFF, 6'h3F);
		wait_drain();
	endtask

	task automatic test_stream_flush();
		send_beat(CMD_LOAD, EosSymbol, 32'h0000_0016, 6'd5);
		send_beat(CMD_END, 9'd0, 32'd0, 6'd0);
		send_beat(CMD_DATA, 9'd255, 32'd0, 6'd0);
		send_beat(CMD_DATA, 9'd255, 32'd0, 6'd0);
		send_beat(CMD_END, 9'd0, 32'd0, 6'd0);
		send_beat(CMD_LOAD, 9'd3, 32'h0000_007F, 6'd7);
		send_beat(CMD_DATA, 9'd3, 32'd0, 6'd0);
		send_beat(CMD_LOAD, EosSymbol, 32'hA5A5_A5A5, 6'd32);
		send_beat(CMD_END, 9'd0, 32'd0, 6'd0);
		send_beat(CMD_LOAD, 9'd4, 32'h0000_0001, 6'd1);
		wait_drain();
	endtask

	task automatic test_random_streams(int count);
		int sent;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 10 || loaded_bytes.size() == 0) begin
				send_beat(CMD_LOAD, 9'($urandom_range(0, 255)), $urandom(), rand_len());
				sent++;
			end else if (r < 13) begin
				send_beat(CMD_LOAD, EosSymbol, $urandom(), rand_len());
				sent++;
			end else if (r < 15) begin
				send_beat(CMD_NONE, 9'($urandom()), $urandom(), 6'($urandom()));
			end else if (r < 17) begin
				send_beat(CMD_LOAD, 9'($urandom_range(257, 511)), $urandom(),
					6'($urandom()));
			end else if (r < 27) begin
				send_beat(CMD_END, 9'($urandom()), $urandom(), 6'($urandom()));
				sent++;
			end else begin
				send_beat(CMD_DATA, pick_data_sym(), $urandom(), 6'($urandom()));
				sent++;
			end
		end
		wait_drain();
	endtask

	task automatic test_steady_streams();
		steady = 1'b1;
		test_random_streams(60);
		steady = 1'b0;
	endtask

	// receiver holds off long enough for the input side to stall
	task automatic test_output_backpressure();
		hold_left = 400;
		for (int i = 0; i < 40; i++)
			send_beat(CMD_DATA, pick_data_sym(), $urandom(), 6'($urandom()));
		send_beat(CMD_END, 9'($urandom()), $urandom(), 6'($urandom()));
		wait_drain();
	endtask

	// output side: check each beat, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (byte_q.size() == 0) begin
					note_failure($sformatf("unexpected beat byte %02h run_end %b stream_end %b",
						out_byte, run_end, stream_end));
				end else begin
					want = byte_q.pop_front();
					if (out_byte !== want.data || run_end !== want.run_end ||
							stream_end !== want.stream_end)
						note_failure($sformatf(
							"byte %02h/%02h run_end %b/%b stream_end %b/%b (exp/got)",
							want.data, out_byte, want.run_end, run_end,
							want.stream_end, stream_end));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("huffman_table_bit_packer_top_tb NOT OK");
		$finish;
	end

	initial begin
		for (int i = 0; i < EntryCount; i++) begin
			code_tbl[i] = '0;
			len_tbl[i] = '0;
			written[i] = 1'b0;
		end
		pend_bits = '0;
		pend_cnt = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_end();
		test_length_saturation();
		test_code_masking();
		test_ignored_beats();
		test_stream_flush();
		test_random_streams(150);
		test_output_backpressure();
		test_steady_streams();
		test_random_streams(150);
		wait_drain();
		repeat (20) @(posedge clk);
		if (byte_q.size() != 0)
			note_failure($sformatf("%0d expected beats never arrived", byte_q.size()));
		if (fail_count == 0)
			$display("huffman_table_bit_packer_top_tb OK");
		else
			$display("huffman_table_bit_packer_top_tb NOT OK");
		$finish;
	end
endmodule
